// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl, sampled on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GHA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define GHA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define GHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define GHA_ASSERT_ALWAYS(lbl, expr)

`define GHA_ASSERT_IMPLIES(lbl, ante, cons)

`define GHA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/gha_pkg.sv =====
`timescale 1ns / 1ps

package gha_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int GEN_BITS    = 16;
  localparam int FREE_DEPTH  = 4096;
  localparam int THRESH_BITS = 13;
  localparam int THRESHOLD_RESET = 1024;

  localparam int TABLE_CAP = 1 << INDEX_BITS;
  localparam int SIZE_BITS = INDEX_BITS + 1;
  localparam int PTR_BITS  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(FREE_DEPTH + 1);
  localparam int CMP_BITS  = (CNT_BITS > THRESH_BITS) ? CNT_BITS : THRESH_BITS;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  typedef logic [1:0]             kind_t;
  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [GEN_BITS-1:0]    gen_t;
  typedef logic [SIZE_BITS-1:0]   size_t;
  typedef logic [PTR_BITS-1:0]    ptr_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [THRESH_BITS-1:0] thresh_t;
  typedef logic [CMP_BITS-1:0]    cmp_t;

  localparam kind_t KIND_CREATE  = 2'd0;
  localparam kind_t KIND_DESTROY = 2'd1;
  localparam kind_t KIND_ALIVE   = 2'd2;
  localparam kind_t KIND_READ    = 2'd3;

  localparam cnt_t    FIFO_FULL     = cnt_t'(FREE_DEPTH);
  localparam ptr_t    PTR_LAST      = ptr_t'(FREE_DEPTH - 1);
  localparam thresh_t THRESH_DEFAULT = thresh_t'(THRESHOLD_RESET);

  // register index of reuse_threshold
  localparam logic REG_THRESHOLD = 1'b0;

endpackage

// ===== rtl/core/generational_handle_allocator.sv =====
// generational handle allocator: one operation at a time, busy while it runs
// a fresh create or a refused op is answered from idle; destroy, alive and
// read after one generation ram read, a reusing create after a fifo ram read
// then a generation ram read; next op is taken in the cycle its result shows
// reset (rst_n, synchronous, active low) clears counts, pointers and sets the
// threshold to 1024; both rams keep their contents and need no clearing pass
`timescale 1ns / 1ps

`include "assert_macros.svh"

module generational_handle_allocator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  gha_pkg::kind_t                         in_kind,
  input  gha_pkg::index_t                        in_handle_index,
  input  gha_pkg::gen_t                          in_handle_generation,
  // result channel
  output logic                                   out_strobe,
  output gha_pkg::index_t                        out_index,
  output gha_pkg::gen_t                          out_generation,
  output logic                                   out_is_alive,
  output gha_pkg::size_t                         out_table_size,
  output logic                                   out_error,
  // apb configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [gha_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [gha_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic [gha_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                   pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIFO = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  gha_pkg::kind_t     op_kind_r, op_kind_nxt;
  gha_pkg::index_t    op_idx_r, op_idx_nxt;
  gha_pkg::gen_t      op_gen_r, op_gen_nxt;
  gha_pkg::ptr_t      head_r, head_nxt;
  gha_pkg::ptr_t      tail_r, tail_nxt;
  gha_pkg::cnt_t      count_r, count_nxt;
  gha_pkg::size_t     alloc_r, alloc_nxt;
  gha_pkg::thresh_t   thresh_r, thresh_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  gha_pkg::index_t    out_index_r, out_index_nxt;
  gha_pkg::gen_t      out_gen_r, out_gen_nxt;
  logic               out_alive_r, out_alive_nxt;
  logic               out_error_r, out_error_nxt;

  // generation table and free fifo
  gha_pkg::gen_t      gen_mem [gha_pkg::TABLE_CAP];
  gha_pkg::index_t    fifo_mem [gha_pkg::FREE_DEPTH];
  gha_pkg::gen_t      gen_rdata_r;
  gha_pkg::index_t    fifo_rdata_r;

  logic               gen_we, gen_re, fifo_we, fifo_re;
  gha_pkg::index_t    gen_waddr, gen_raddr;
  gha_pkg::gen_t      gen_wdata;

  logic               accept;
  logic               can_reuse;
  logic               table_full;
  logic               beyond_size;
  logic               fifo_full;
  logic               cfg_write;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  assign can_reuse   = gha_pkg::cmp_t'(count_r) > gha_pkg::cmp_t'(thresh_r);
  assign table_full  = alloc_r[gha_pkg::INDEX_BITS];
  assign beyond_size = {1'b0, in_handle_index} >= alloc_r;
  assign fifo_full   = (count_r == gha_pkg::FIFO_FULL);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == gha_pkg::REG_THRESHOLD)
                ? gha_pkg::APB_DATA_BITS'(thresh_r) : '0;

  always_comb begin
    state_nxt      = state_r;
    op_kind_nxt    = op_kind_r;
    op_idx_nxt     = op_idx_r;
    op_gen_nxt     = op_gen_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    alloc_nxt      = alloc_r;
    thresh_nxt     = thresh_r;
    out_strobe_nxt = 1'b0;
    out_index_nxt  = out_index_r;
    out_gen_nxt    = out_gen_r;
    out_alive_nxt  = out_alive_r;
    out_error_nxt  = out_error_r;
    gen_we    = 1'b0;
    gen_re    = 1'b0;
    fifo_we   = 1'b0;
    fifo_re   = 1'b0;
    gen_waddr = op_idx_r;
    gen_wdata = gen_rdata_r + 1'b1;
    gen_raddr = in_handle_index;

    if (cfg_write && (paddr[2] == gha_pkg::REG_THRESHOLD)) begin
      thresh_nxt = pwdata[gha_pkg::THRESH_BITS-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_kind_nxt = in_kind;
          op_idx_nxt  = in_handle_index;
          op_gen_nxt  = in_handle_generation;
          if (in_kind == gha_pkg::KIND_CREATE) begin
            if (can_reuse) begin
              fifo_re   = 1'b1;
              head_nxt  = (head_r == gha_pkg::PTR_LAST) ? '0 : head_r + 1'b1;
              count_nxt = count_r - 1'b1;
              state_nxt = ST_FIFO;
            end else begin
              out_strobe_nxt = 1'b1;
              out_alive_nxt  = 1'b0;
              out_gen_nxt    = '0;
              if (table_full) begin
                out_index_nxt = '0;
                out_error_nxt = 1'b1;
              end else begin
                // fresh index starts at generation zero
                gen_we        = 1'b1;
                gen_waddr     = alloc_r[gha_pkg::INDEX_BITS-1:0];
                gen_wdata     = '0;
                out_index_nxt = alloc_r[gha_pkg::INDEX_BITS-1:0];
                out_error_nxt = 1'b0;
                alloc_nxt     = alloc_r + 1'b1;
              end
            end
          end else if (beyond_size
                       || (in_kind == gha_pkg::KIND_DESTROY && fifo_full)) begin
            out_strobe_nxt = 1'b1;
            out_index_nxt  = '0;
            out_gen_nxt    = '0;
            out_alive_nxt  = 1'b0;
            out_error_nxt  = 1'b1;
          end else begin
            gen_re    = 1'b1;
            state_nxt = ST_GEN;
          end
        end
      end
      ST_FIFO: begin
        // oldest freed index is back, fetch its generation
        gen_re     = 1'b1;
        gen_raddr  = fifo_rdata_r;
        op_idx_nxt = fifo_rdata_r;
        state_nxt  = ST_GEN;
      end
      ST_GEN: begin
        out_strobe_nxt = 1'b1;
        out_index_nxt  = '0;
        out_gen_nxt    = '0;
        out_alive_nxt  = 1'b0;
        out_error_nxt  = 1'b0;
        state_nxt      = ST_IDLE;
        unique case (op_kind_r)
          gha_pkg::KIND_DESTROY: begin
            gen_we    = 1'b1;
            fifo_we   = 1'b1;
            tail_nxt  = (tail_r == gha_pkg::PTR_LAST) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
          end
          gha_pkg::KIND_ALIVE: begin
            out_alive_nxt = (gen_rdata_r == op_gen_r);
          end
          gha_pkg::KIND_CREATE, gha_pkg::KIND_READ: begin
            out_index_nxt = op_idx_r;
            out_gen_nxt   = gen_rdata_r;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (gen_re) begin
      gen_rdata_r <= gen_mem[gen_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail_r] <= op_idx_r;
    end
    if (fifo_re) begin
      fifo_rdata_r <= fifo_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      alloc_r      <= '0;
      thresh_r     <= gha_pkg::THRESH_DEFAULT;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      alloc_r      <= alloc_nxt;
      thresh_r     <= thresh_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_kind_r   <= op_kind_nxt;
    op_idx_r    <= op_idx_nxt;
    op_gen_r    <= op_gen_nxt;
    out_index_r <= out_index_nxt;
    out_gen_r   <= out_gen_nxt;
    out_alive_r <= out_alive_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_index      = out_index_r;
  assign out_generation = out_gen_r;
  assign out_is_alive   = out_alive_r;
  assign out_error      = out_error_r;
  // table size only moves with an accepted op, so it is current while shown
  assign out_table_size = alloc_r;

  `GHA_ASSERT_ALWAYS(a_count_bound, count_r <= gha_pkg::FIFO_FULL)
  `GHA_ASSERT_ALWAYS(a_alloc_bound, !(table_full && (|alloc_r[gha_pkg::INDEX_BITS-1:0])))
  `GHA_ASSERT_IMPLIES(a_empty_ptrs, count_r == '0, head_r == tail_r)
  `GHA_ASSERT_NEXT(a_accept_progress, accept, out_strobe_r || busy)
  `GHA_ASSERT_IMPLIES(a_strobe_source, out_strobe_r, $past(accept) || $past(state_r == ST_GEN))

endmodule
